>>> hw/rtl/header_length_xor_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef HEADER_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`define HEADER_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLXFR_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hlxfr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HLXFR_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hlxfr assertion failed");

`endif

>>> hw/rtl/hlxfr_pkg.sv
package hlxfr_pkg;

  // Header bytes of a frame.
  localparam logic [7:0] SYNC0      = 8'h55;
  localparam logic [7:0] SYNC1      = 8'h4E;
  localparam logic [7:0] SYNC2      = 8'h45;
  localparam logic [7:0] SYNC3      = 8'h52;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] COLON      = 8'h3A;
  localparam logic [7:0] ALIVE_INIT = 8'hF0;

  // Checksum seed for the fixed header bytes; the length byte is folded in later.
  localparam logic [7:0] HDR_XOR = SYNC0 ^ SYNC1 ^ SYNC2 ^ SYNC3 ^ ZERO_BYTE ^ COLON;

  typedef enum logic [2:0] {
    PH_SYNC0  = 3'd0,
    PH_SYNC1  = 3'd1,
    PH_SYNC2  = 3'd2,
    PH_SYNC3  = 3'd3,
    PH_LENGTH = 3'd4,
    PH_ZERO   = 3'd5,
    PH_COLON  = 3'd6,
    PH_BODY   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

endpackage

>>> hw/rtl/header_length_xor_frame_receiver.sv
// Frame receiver for a byte stream: it hunts for the sync bytes 0x55 0x4E 0x45 0x52,
// takes a length byte, expects 0x00 and ':', then counts length bytes of body whose
// last byte is an XOR checksum over every earlier frame byte. Every input beat yields
// exactly one registered output beat: frame status (none, accepted, bad checksum),
// the first body byte and an alive request when an accepted frame starts with the
// programmed alive code. A length byte of zero means a 256-byte body. The block takes
// one beat per cycle; the only loop is the per-byte state update, which sits between
// the input side and a single output register, and the input stays ready while that
// register is empty or being drained in the same cycle. The user must write the alive
// code via cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
`include "header_length_xor_frame_receiver_assert.svh"

module header_length_xor_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Alive code register write.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Received bytes. tdata[7:0] = rx_byte.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Results. tdata[1:0] = frame_status, [9:2] = first_payload,
  // [10] = alive_request, [15:11] = zero.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o
);

  hlxfr_pkg::phase_e  phase_q, phase_d;
  logic [7:0]         bytes_left_q, bytes_left_d;
  logic [7:0]         run_xor_q, run_xor_d;
  logic [7:0]         saved_first_q, saved_first_d;
  logic               first_taken_q, first_taken_d;
  logic [7:0]         alive_code_q;

  logic               out_valid_q;
  hlxfr_pkg::status_e status_q, status_d;
  logic [7:0]         first_q, first_d;
  logic               alive_q, alive_d;

  logic               in_accept;
  logic               rehunt;
  logic [7:0]         rx_byte;
  logic [7:0]         body_first;
  logic               is_check;

  assign rx_byte         = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // The checksum byte of a one-byte body is also its first byte.
  assign body_first = first_taken_q ? saved_first_q : rx_byte;
  assign is_check   = (bytes_left_q == 8'd1);

  // Header and body sequencing. A header mismatch after the first sync byte
  // re-examines the same byte as a possible first sync byte.
  always_comb begin
    rehunt  = 1'b0;
    phase_d = phase_q;
    unique case (phase_q)
      hlxfr_pkg::PH_SYNC0: begin
        if (rx_byte == hlxfr_pkg::SYNC0) phase_d = hlxfr_pkg::PH_SYNC1;
      end
      hlxfr_pkg::PH_SYNC1: begin
        if (rx_byte == hlxfr_pkg::SYNC1) phase_d = hlxfr_pkg::PH_SYNC2;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_SYNC2: begin
        if (rx_byte == hlxfr_pkg::SYNC2) phase_d = hlxfr_pkg::PH_SYNC3;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_SYNC3: begin
        if (rx_byte == hlxfr_pkg::SYNC3) phase_d = hlxfr_pkg::PH_LENGTH;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_LENGTH: begin
        phase_d = hlxfr_pkg::PH_ZERO;
      end
      hlxfr_pkg::PH_ZERO: begin
        if (rx_byte == hlxfr_pkg::ZERO_BYTE) phase_d = hlxfr_pkg::PH_COLON;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_COLON: begin
        if (rx_byte == hlxfr_pkg::COLON) phase_d = hlxfr_pkg::PH_BODY;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_BODY: begin
        if (is_check) phase_d = hlxfr_pkg::PH_SYNC0;
      end
      default: phase_d = hlxfr_pkg::PH_SYNC0;
    endcase
    if (rehunt) begin
      phase_d = (rx_byte == hlxfr_pkg::SYNC0) ? hlxfr_pkg::PH_SYNC1 : hlxfr_pkg::PH_SYNC0;
    end
  end

  // Counter, checksum and result for the current byte.
  always_comb begin
    bytes_left_d  = bytes_left_q;
    run_xor_d     = run_xor_q;
    saved_first_d = saved_first_q;
    first_taken_d = first_taken_q;
    status_d      = hlxfr_pkg::ST_NONE;
    first_d       = 8'h00;
    alive_d       = 1'b0;
    unique case (phase_q)
      hlxfr_pkg::PH_LENGTH: begin
        bytes_left_d = rx_byte;
      end
      hlxfr_pkg::PH_COLON: begin
        if (rx_byte == hlxfr_pkg::COLON) begin
          run_xor_d     = hlxfr_pkg::HDR_XOR ^ bytes_left_q;
          first_taken_d = 1'b0;
        end
      end
      hlxfr_pkg::PH_BODY: begin
        saved_first_d = body_first;
        first_taken_d = 1'b1;
        if (is_check) begin
          first_d      = body_first;
          bytes_left_d = 8'd0;
          if (run_xor_q == rx_byte) begin
            status_d = hlxfr_pkg::ST_OK;
            alive_d  = (body_first == alive_code_q);
          end else begin
            status_d = hlxfr_pkg::ST_BAD;
          end
        end else begin
          run_xor_d    = run_xor_q ^ rx_byte;
          bytes_left_d = bytes_left_q - 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= hlxfr_pkg::PH_SYNC0;
      bytes_left_q  <= 8'd0;
      run_xor_q     <= 8'd0;
      saved_first_q <= 8'd0;
      first_taken_q <= 1'b0;
    end else if (in_accept) begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      run_xor_q     <= run_xor_d;
      saved_first_q <= saved_first_d;
      first_taken_q <= first_taken_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_code_q <= hlxfr_pkg::ALIVE_INIT;
    end else if (cfg_we_i) begin
      alive_code_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      first_q  <= first_d;
      alive_q  <= alive_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, alive_q, first_q, status_q};

  // An alive request only comes with an accepted frame.
  `HLXFR_ASSERT_IMP(a_alive_only_ok, clk_i, rst_ni, out_valid_q && alive_q,
                    status_q == hlxfr_pkg::ST_OK)
  // Outside the body no frame can complete.
  `HLXFR_ASSERT_NXT(a_status_from_body, clk_i, rst_ni,
                    in_accept && (phase_q != hlxfr_pkg::PH_BODY),
                    status_q == hlxfr_pkg::ST_NONE)
  // A body byte that is not the checksum keeps the block in the body.
  `HLXFR_ASSERT_NXT(a_body_stays, clk_i, rst_ni,
                    in_accept && (phase_q == hlxfr_pkg::PH_BODY) && !is_check,
                    (phase_q == hlxfr_pkg::PH_BODY) && first_taken_q)
  // A checksum byte always closes the frame with a status.
  `HLXFR_ASSERT_NXT(a_check_closes, clk_i, rst_ni,
                    in_accept && (phase_q == hlxfr_pkg::PH_BODY) && is_check,
                    (phase_q == hlxfr_pkg::PH_SYNC0) && (status_q != hlxfr_pkg::ST_NONE))

endmodule

>>> test/header_length_xor_frame_receiver_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the alive code write port. It keeps its own copy of the
// deframer state, works out the report for every accepted byte and compares each
// result beat against the oldest report still due.
module header_length_xor_frame_receiver_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  // Same bit order as the result tdata: status lowest, padding highest.
  typedef struct packed {
    logic [4:0]         pad;
    logic               alive;
    logic [7:0]         first;
    hlxfr_pkg::status_e status;
  } frame_report_t;

  hlxfr_pkg::phase_e phase;
  logic [7:0]        body_left;
  logic [7:0]        body_xor;
  logic [7:0]        lead_byte;
  logic              lead_seen;
  logic [7:0]        alive_code;
  frame_report_t     reports_due[$];

  // Advances the tracked deframer by one received byte and returns its report.
  function automatic frame_report_t track_deframer(input logic [7:0] rx);
    frame_report_t rep;
    logic          rehunt;
    rep        = '0;
    rep.status = hlxfr_pkg::ST_NONE;
    rehunt     = 1'b0;
    case (phase)
      hlxfr_pkg::PH_SYNC0: begin
        if (rx == hlxfr_pkg::SYNC0) phase = hlxfr_pkg::PH_SYNC1;
      end
      hlxfr_pkg::PH_SYNC1: begin
        if (rx == hlxfr_pkg::SYNC1) phase = hlxfr_pkg::PH_SYNC2;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_SYNC2: begin
        if (rx == hlxfr_pkg::SYNC2) phase = hlxfr_pkg::PH_SYNC3;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_SYNC3: begin
        if (rx == hlxfr_pkg::SYNC3) phase = hlxfr_pkg::PH_LENGTH;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_LENGTH: begin
        body_left = rx;
        phase     = hlxfr_pkg::PH_ZERO;
      end
      hlxfr_pkg::PH_ZERO: begin
        if (rx == hlxfr_pkg::ZERO_BYTE) phase = hlxfr_pkg::PH_COLON;
        else rehunt = 1'b1;
      end
      hlxfr_pkg::PH_COLON: begin
        if (rx == hlxfr_pkg::COLON) begin
          body_xor  = hlxfr_pkg::HDR_XOR ^ body_left;
          lead_seen = 1'b0;
          phase     = hlxfr_pkg::PH_BODY;
        end else begin
          rehunt = 1'b1;
        end
      end
      default: begin
        if (!lead_seen) begin
          lead_byte = rx;
          lead_seen = 1'b1;
        end
        if (body_left == 8'd1) begin
          // This is the checksum byte.
          rep.first = lead_byte;
          if (body_xor == rx) begin
            rep.status = hlxfr_pkg::ST_OK;
            rep.alive  = (lead_byte == alive_code);
          end else begin
            rep.status = hlxfr_pkg::ST_BAD;
          end
          phase     = hlxfr_pkg::PH_SYNC0;
          body_left = 8'd0;
        end else begin
          body_xor  = body_xor ^ rx;
          body_left = body_left - 8'd1;
        end
      end
    endcase
    // A broken header byte may itself open the next frame.
    if (rehunt) phase = (rx == hlxfr_pkg::SYNC0) ? hlxfr_pkg::PH_SYNC1 : hlxfr_pkg::PH_SYNC0;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t want;
    frame_report_t seen;
    if (!rst_ni) begin
      phase         = hlxfr_pkg::PH_SYNC0;
      body_left     = 8'd0;
      body_xor      = 8'd0;
      lead_byte     = 8'd0;
      lead_seen     = 1'b0;
      alive_code    = hlxfr_pkg::ALIVE_INIT;
      reports_due.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      // A result leaving now belongs to an earlier byte, so it is checked first.
      if (m_valid_i && m_ready_i) begin
        seen = frame_report_t'(m_data_i);
        if (reports_due.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result beat %h arrived with no report due", $realtime, m_data_i);
          mismatches_o++;
        end else begin
          want = reports_due.pop_front();
          if (seen.status !== want.status || seen.first !== want.first ||
              seen.alive !== want.alive || seen.pad !== want.pad) begin
            if (mismatches_o < 10)
              $display("%0t: report mismatch: expected status %0d first %h alive %b pad %h,",
                       $realtime, want.status, want.first, want.alive, want.pad,
                       " got status %0d first %h alive %b pad %h",
                       seen.status, seen.first, seen.alive, seen.pad);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) alive_code = cfg_wdata_i;
      if (s_valid_i && s_ready_i) reports_due.push_back(track_deframer(s_data_i));
      outstanding_o = reports_due.size();
    end
  end

endmodule

>>> test/header_length_xor_frame_receiver_tb.sv
`timescale 1ns / 1ps

// Top of the frame receiver bench. It drives bytes and the alive code, runs a random
// receiver, and leaves all prediction and comparison to the checker instance.
module header_length_xor_frame_receiver_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 250;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] rx_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [1:0] status, [9:2] first payload, [10] alive, rest zero

  int          mismatches;
  int          outstanding;
  int          cycle_count;
  int          bytes_sent;
  bit          quiet;            // When set, neither side inserts idle cycles.
  bit          hold_off_req;     // Asks the receiver for one long stall.
  logic [7:0]  alive_now;        // Alive code the block currently holds.

  header_length_xor_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  header_length_xor_frame_receiver_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_i     (s_axis_tready_o),
    .s_data_i      (s_axis_tdata_i),
    .m_valid_i     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_data_i      (m_axis_tdata_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side. Each beat is preceded by a random stall unless the bench is in a quiet
  // stretch. A pending hold request stalls the output for a long stretch so the single
  // output register fills and the input side backs up.
  initial begin
    int pause;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      pause = quiet ? 0 : $urandom_range(0, 4);
      if (pause != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  // Offers one byte after a random gap and returns at the falling edge after the beat
  // was taken. Valid stays high on return so back-to-back beats need no extra step.
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until every report has come out of the block.
  // Each byte gives exactly one result, so a short pause after that leaves it idle.
  task automatic drain_reports();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic program_alive(input logic [7:0] code);
    drain_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    alive_now   = code;
  endtask

  // Sends a complete frame. A length byte of zero gives a 256-byte body. The lead
  // byte is the first payload byte unless the body is only the checksum.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] lead, input bit spoil);
    logic [7:0] sum;
    logic [7:0] rx;
    int         body;
    sum  = hlxfr_pkg::HDR_XOR ^ len;
    body = (len == 8'd0) ? 256 : int'(len);
    send_byte(hlxfr_pkg::SYNC0);
    send_byte(hlxfr_pkg::SYNC1);
    send_byte(hlxfr_pkg::SYNC2);
    send_byte(hlxfr_pkg::SYNC3);
    send_byte(len);
    send_byte(hlxfr_pkg::ZERO_BYTE);
    send_byte(hlxfr_pkg::COLON);
    for (int i = 0; i < body - 1; i++) begin
      rx  = (i == 0) ? lead : 8'($urandom);
      sum = sum ^ rx;
      send_byte(rx);
    end
    if (spoil) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Sends a header prefix cut off by a wrong byte. The length position takes any
  // value, so it is never the one that breaks. The wrong byte is often a first sync
  // byte, which must start a new hunt on the spot.
  task automatic send_broken_header();
    logic [7:0] hdr [7];
    int         cut;
    logic [7:0] bad;
    hdr = '{hlxfr_pkg::SYNC0, hlxfr_pkg::SYNC1, hlxfr_pkg::SYNC2, hlxfr_pkg::SYNC3,
            8'($urandom), hlxfr_pkg::ZERO_BYTE, hlxfr_pkg::COLON};
    do cut = $urandom_range(1, 6); while (cut == 4);
    for (int i = 0; i < cut; i++) send_byte(hdr[i]);
    bad = ($urandom_range(0, 2) == 0) ? hlxfr_pkg::SYNC0 : 8'($urandom);
    if (bad == hdr[cut]) bad = bad ^ 8'h01;
    send_byte(bad);
  endtask

  // One random frame: mostly short bodies, some longer, a quarter with a bad
  // checksum, and a third that lead with the current alive code.
  task automatic send_random_frame();
    logic [7:0] len;
    logic [7:0] lead;
    len  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(1, 12));
    lead = ($urandom_range(0, 2) == 0) ? alive_now : 8'($urandom);
    send_frame(len, lead, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [7:0] codes [4];
    int         phase_start;
    int         choice;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 8'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'd0;
    bytes_sent      = 0;
    quiet           = 1'b0;
    hold_off_req    = 1'b0;
    alive_now       = hlxfr_pkg::ALIVE_INIT;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed bytes at the reset alive code. Noise at both byte extremes is dropped
    // by the hunt, then a first sync byte breaks a header in its third position and
    // opens a fresh one.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(hlxfr_pkg::SYNC0);
    send_byte(hlxfr_pkg::SYNC1);
    send_byte(hlxfr_pkg::SYNC0);
    send_byte(hlxfr_pkg::SYNC1);
    send_byte(hlxfr_pkg::SYNC2);
    send_byte(hlxfr_pkg::SYNC3);
    // Length one: the body is just the checksum, which is also the first payload.
    send_byte(8'd1);
    send_byte(hlxfr_pkg::ZERO_BYTE);
    send_byte(hlxfr_pkg::COLON);
    send_byte(hlxfr_pkg::HDR_XOR ^ 8'd1);
    // Header broken by a byte that is no sync byte at all.
    send_byte(hlxfr_pkg::SYNC0);
    send_byte(hlxfr_pkg::SYNC1);
    send_byte(hlxfr_pkg::SYNC2);
    send_byte(8'h00);
    // A good frame that carries the alive code, then a spoiled length-one frame.
    send_frame(8'd2, hlxfr_pkg::ALIVE_INIT, 1'b0);
    send_frame(8'd1, 8'h00, 1'b1);

    // Random phases, each with its own alive code, both extremes among them.
    codes = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    for (int p = 0; p < 4; p++) begin
      program_alive(codes[p]);
      phase_start = bytes_sent;
      case (p)
        0: hold_off_req = 1'b1;
        1: send_frame(8'd0, alive_now, 1'b0);
        2: send_frame(8'd255, 8'($urandom), 1'b0);
        default: send_frame(8'd0, 8'($urandom), 1'b1);
      endcase
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) quiet = !quiet;
        choice = $urandom_range(0, 19);
        if (choice <= 13) begin
          send_random_frame();
        end else if (choice <= 16) begin
          send_broken_header();
        end else if (choice <= 18) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else begin
          drain_reports();
        end
      end
    end

    // Every byte is in; wait for the last reports before the final check.
    quiet = 1'b0;
    drain_reports();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
